/* src/sdrt_pkg.sv */
`default_nettype none

package sdrt_pkg;

  // Table geometry.
  localparam int CAPACITY = 64;
  localparam int ID_BYTES = 8;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);

  // Field widths of the input and result transactions.
  localparam int ID_W     = 64;
  localparam int DAY_IN_W = 8;
  localparam int MON_IN_W = 8;
  localparam int YEAR_W   = 16;
  localparam int IDX_W    = 6;
  localparam int STATUS_W = 3;
  localparam int DAY_W    = 5;
  localparam int MON_W    = 4;
  localparam int CFG_W    = 7;
  localparam int DATE_W   = YEAR_W + MON_W + DAY_W;
  localparam int ENTRY_W  = DATE_W + ID_W;
  localparam int LIM_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int RIX_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  // Only the leading ID_BYTES bytes of an identifier are kept.
  localparam logic [ID_W-1:0] ID_MASK = {ID_W{1'b1}} << (8 * (8 - ID_BYTES));

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

  // Operation selector carried in the input tuser.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // Calendar constants.
  localparam logic [MON_IN_W-1:0] MON_FEB = 8'd2;
  localparam logic [MON_IN_W-1:0] MON_APR = 8'd4;
  localparam logic [MON_IN_W-1:0] MON_JUN = 8'd6;
  localparam logic [MON_IN_W-1:0] MON_SEP = 8'd9;
  localparam logic [MON_IN_W-1:0] MON_NOV = 8'd11;
  localparam logic [MON_IN_W-1:0] MON_MAX = 8'd12;
  localparam logic [DAY_W-1:0] DAYS_LONG     = 5'd31;
  localparam logic [DAY_W-1:0] DAYS_SHORT    = 5'd30;
  localparam logic [DAY_W-1:0] DAYS_FEB_LEAP = 5'd29;
  localparam logic [DAY_W-1:0] DAYS_FEB      = 5'd28;
  // A year divisible by 100 is one divisible by 4 and 25; by 400, by 16 and 25.
  localparam logic [5:0] CENT_FACTOR = 6'd25;
  // The quotient of a year by 25 is the year times 2^22 / 25 rounded up, shifted down
  // by 22; the rounding error stays below one for every 16-bit year.
  localparam int CENT_SHIFT   = 22;
  localparam int CENT_RECIP_W = 18;
  localparam logic [CENT_RECIP_W-1:0] CENT_RECIP = 18'd167773;
  localparam int CENT_PROD_W  = YEAR_W + CENT_RECIP_W;
  localparam int CENT_Q_W     = CENT_PROD_W - CENT_SHIFT;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_BAD_DATE = 3'd1,
    STAT_DUP      = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_RANGE    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DATE,
    S_SCAN,
    S_SHIFT,
    S_PUT,
    S_READ,
    S_READ_WAIT,
    S_DONE
  } state_t;

  // Result handed from the date checker to the controller.
  typedef struct packed {
    logic done;
    logic ok;
  } date_res_t;

endpackage

`default_nettype wire

/* src/sdrt_ram.sv */
`default_nettype none

module sdrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/sdrt_date_unit.sv */
`default_nettype none

module sdrt_date_unit
  import sdrt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [DAY_IN_W-1:0] day,
  input  wire logic [MON_IN_W-1:0] month,
  input  wire logic [YEAR_W-1:0]   year,
  output date_res_t                res
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [YEAR_W-1:0]    year_r, year_nxt;
  logic [MON_IN_W-1:0]  mon_r, mon_nxt;
  logic [DAY_IN_W-1:0]  day_r, day_nxt;
  logic [CENT_Q_W-1:0]  quot_r, quot_nxt;
  logic                 div25, leap;
  logic [DAY_W-1:0]     last_day;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    year_r <= year_nxt;
    mon_r  <= mon_nxt;
    day_r  <= day_nxt;
    quot_r <= quot_nxt;
  end

  // Capture the date, then in the cycle after register the year's quotient by 25.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    year_nxt = year_r;
    mon_nxt  = mon_r;
    day_nxt  = day_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      year_nxt = year;
      mon_nxt  = month;
      day_nxt  = day;
    end else if (busy_r) begin
      quot_nxt = CENT_Q_W'((CENT_PROD_W'(year_r) * CENT_PROD_W'(CENT_RECIP)) >> CENT_SHIFT);
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  // Gregorian leap rule and the length of the month.
  always_comb begin
    div25 = ((YEAR_W'(quot_r) * YEAR_W'(CENT_FACTOR)) == year_r);
    leap  = (year_r[1:0] == 2'b00) && (!div25 || (year_r[3:0] == 4'b0000));
    if (mon_r == MON_FEB) begin
      last_day = leap ? DAYS_FEB_LEAP : DAYS_FEB;
    end else if (mon_r == MON_APR || mon_r == MON_JUN || mon_r == MON_SEP ||
                 mon_r == MON_NOV) begin
      last_day = DAYS_SHORT;
    end else begin
      last_day = DAYS_LONG;
    end
    res.done = done_r;
    res.ok   = (mon_r != '0) && (mon_r <= MON_MAX) && (day_r != '0) &&
               (day_r <= DAY_IN_W'(last_day));
  end

endmodule

`default_nettype wire

/* src/sorted_dated_record_table.sv */
// Sorted record table: identifiers with dates, kept in key order in one RAM.
// Insert: date check, scan of every stored entry, shift up of the entries at and above the
// sorted position (none when the new entry goes last), write of the new entry, handoff.
// A bad date ends after the date check, a duplicate or a full table after the scan; a read
// past the end skips the RAM read. One transaction at a time; the next is taken in the
// cycle after handoff, even while that result waits. Reset empties the table at once.
`default_nettype none

module sorted_dated_record_table
  import sdrt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [103:0]      in_tdata,   // id, day, month, year, index, zero fill
  input  wire logic              in_tuser,   // mode
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [95:0]            out_tdata,  // entry_id, entry_day, entry_month,
                                             // entry_year, stored_count
  output logic [STATUS_W-1:0]    out_tuser,  // status
  input  wire logic              cfg_wr_en,
  input  wire logic [CFG_W-1:0]  cfg_wr_data
);

  state_t               state_r, state_nxt;
  logic [CFG_W-1:0]     cap_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  logic [DATE_W-1:0]    date_r, date_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     scan_r, scan_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  logic                 pend_r, pend_nxt;
  logic                 dup_r, dup_nxt;
  logic                 more_r, more_nxt;
  logic [ADDR_W-1:0]    shaddr_r, shaddr_nxt;
  logic [ADDR_W-1:0]    rdq_r, rdq_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [ENTRY_W-1:0]   res_entry_r, res_entry_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [95:0]          out_data_r, out_data_nxt;
  logic [STATUS_W-1:0]  out_user_r, out_user_nxt;

  logic                 in_hs;
  logic                 date_start;
  date_res_t            date_res;
  logic                 ram_wr_en, ram_rd_en;
  logic [ADDR_W-1:0]    ram_wr_addr, ram_rd_addr;
  logic [ENTRY_W-1:0]   ram_wr_data, ram_rd_data;
  logic [ENTRY_W-1:0]   new_key;
  logic [LIM_W-1:0]     limit;
  logic [RIX_W-1:0]     idx_ext;

  assign in_hs      = in_tvalid && in_tready;
  assign date_start = in_hs && (in_tuser == MODE_INSERT);
  assign new_key    = {date_r, id_r};
  assign idx_ext    = RIX_W'(idx_r);
  assign limit      = (LIM_W'(cap_r) < LIM_W'(CAPACITY)) ? LIM_W'(cap_r) : LIM_W'(CAPACITY);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  sdrt_date_unit u_date (
    .clk   (clk),
    .rst_n (rst_n),
    .start (date_start),
    .day   (in_tdata[71:64]),
    .month (in_tdata[79:72]),
    .year  (in_tdata[95:80]),
    .res   (date_res)
  );

  sdrt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // Control state and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      more_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      more_r      <= more_nxt;
      out_valid_r <= out_valid_nxt;
    end
    id_r         <= id_nxt;
    date_r       <= date_nxt;
    idx_r        <= idx_nxt;
    scan_r       <= scan_nxt;
    pos_r        <= pos_nxt;
    dup_r        <= dup_nxt;
    shaddr_r     <= shaddr_nxt;
    rdq_r        <= rdq_nxt;
    res_status_r <= res_status_nxt;
    res_entry_r  <= res_entry_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

  // Sequencer: for an insert, date check, scan, shift up, write the new entry; for a read, read the entry; then report.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    id_nxt         = id_r;
    date_nxt       = date_r;
    idx_nxt        = idx_r;
    scan_nxt       = scan_r;
    pos_nxt        = pos_r;
    pend_nxt       = pend_r;
    dup_nxt        = dup_r;
    more_nxt       = more_r;
    shaddr_nxt     = shaddr_r;
    rdq_nxt        = rdq_r;
    res_status_nxt = res_status_r;
    res_entry_nxt  = res_entry_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    in_tready      = 1'b0;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = rdq_r + 1'b1;
    ram_wr_data    = ram_rd_data;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = scan_r[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_hs) begin
          id_nxt         = in_tdata[63:0] & ID_MASK;
          date_nxt       = {in_tdata[95:80], in_tdata[75:72], in_tdata[68:64]};
          idx_nxt        = in_tdata[101:96];
          res_status_nxt = STAT_OK;
          res_entry_nxt  = '0;
          state_nxt      = (in_tuser == MODE_READ) ? S_READ : S_DATE;
        end
      end

      S_DATE: begin
        if (date_res.done) begin
          if (date_res.ok) begin
            scan_nxt  = '0;
            pos_nxt   = '0;
            pend_nxt  = 1'b0;
            dup_nxt   = 1'b0;
            state_nxt = S_SCAN;
          end else begin
            res_status_nxt = STAT_BAD_DATE;
            state_nxt      = S_DONE;
          end
        end
      end

      // One entry read per cycle; compare the one read in the cycle before.
      S_SCAN: begin
        pend_nxt = 1'b0;
        if (scan_r < count_r) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = scan_r[ADDR_W-1:0];
          scan_nxt    = scan_r + 1'b1;
          pend_nxt    = 1'b1;
        end
        if (pend_r) begin
          if (ram_rd_data[ID_W-1:0] == id_r) begin
            dup_nxt = 1'b1;
          end
          if (ram_rd_data < new_key) begin
            pos_nxt = pos_r + 1'b1;
          end
        end else if (scan_r >= count_r) begin
          if (dup_r) begin
            res_status_nxt = STAT_DUP;
            state_nxt      = S_DONE;
          end else if (LIM_W'(count_r) >= limit) begin
            res_status_nxt = STAT_FULL;
            state_nxt      = S_DONE;
          end else if (count_r > pos_r) begin
            shaddr_nxt = ADDR_W'(count_r - 1'b1);
            more_nxt   = 1'b1;
            state_nxt  = S_SHIFT;
          end else begin
            state_nxt = S_PUT;
          end
        end
      end

      // Read entry a, write it to a + 1 in the next cycle, walking down to pos.
      S_SHIFT: begin
        pend_nxt = 1'b0;
        if (pend_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = rdq_r + 1'b1;
          ram_wr_data = ram_rd_data;
        end
        if (more_r) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = shaddr_r;
          rdq_nxt     = shaddr_r;
          pend_nxt    = 1'b1;
          if (shaddr_r == pos_r[ADDR_W-1:0]) begin
            more_nxt = 1'b0;
          end else begin
            shaddr_nxt = shaddr_r - 1'b1;
          end
        end else if (!pend_r) begin
          state_nxt = S_PUT;
        end
      end

      S_PUT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = pos_r[ADDR_W-1:0];
        ram_wr_data = new_key;
        count_nxt   = count_r + 1'b1;
        state_nxt   = S_DONE;
      end

      S_READ: begin
        if (idx_ext >= RIX_W'(count_r) || idx_ext >= RIX_W'(CAPACITY)) begin
          res_status_nxt = STAT_RANGE;
          state_nxt      = S_DONE;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = idx_ext[ADDR_W-1:0];
          state_nxt   = S_READ_WAIT;
        end
      end

      S_READ_WAIT: begin
        res_entry_nxt = ram_rd_data;
        state_nxt     = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = res_status_r;
          out_data_nxt  = {
            7'(count_r),
            res_entry_r[ENTRY_W-1 -: YEAR_W],
            res_entry_r[ID_W+DAY_W +: MON_W],
            res_entry_r[ID_W +: DAY_W],
            res_entry_r[ID_W-1:0]
          };
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The table never holds more entries than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // The count grows by one exactly when a new entry is written.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT) |=> (count_r == $past(count_r) + 1'b1))
    else $error("count did not advance on insert");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_PUT) |=> $stable(count_r))
    else $error("count changed outside insert");

  // The RAM is written only while shifting or placing an entry.
  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> (state_r == S_SHIFT || state_r == S_PUT))
    else $error("table write outside insert");

  // An accepted transaction always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_hs |=> (state_r != S_IDLE))
    else $error("accepted transaction not started");

endmodule

`default_nettype wire
